// File: sv/sfsd_pkg.sv
// sfsd_pkg: widths, header constants and the phase type of the sensor frame
// sync decoder. No dependencies; used by the channel interfaces and the top level.

package sfsd_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned LEN_W          = 11;
  localparam int unsigned SLOT_W         = 10;
  localparam int unsigned VALUE_W        = 15;
  localparam int unsigned WINDOW_W       = 3 * BYTE_W;

  localparam int unsigned RING_DEPTH_DEF = 1024;
  localparam int unsigned LEN_MAX        = (1 << LEN_W) - 1;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

  localparam logic [BYTE_W-1:0] HDR_BYTE0 = 8'hFF;
  localparam logic [BYTE_W-1:0] HDR_BYTE1 = 8'h18;
  localparam logic [BYTE_W-1:0] HDR_BYTE2 = 8'h00;
  localparam logic [WINDOW_W-1:0] HEADER_WORD = {HDR_BYTE0, HDR_BYTE1, HDR_BYTE2};

  localparam logic [6:0] HUNDREDTHS_PER_UNIT = 7'd100;

  typedef enum logic {
    KIND_SAMPLE  = 1'b0,
    KIND_RETRACT = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'd0,
    PH_HIGH   = 4'd1,
    PH_LOW    = 4'd2,
    PH_SKIP0  = 4'd3,
    PH_SKIP1  = 4'd4,
    PH_SKIP2  = 4'd5,
    PH_SKIP3  = 4'd6,
    PH_CHECK0 = 4'd7,
    PH_CHECK1 = 4'd8,
    PH_CHECK2 = 4'd9
  } phase_t;

endpackage

// File: sv/sfsd_if.sv
// sfsd_rx_if and sfsd_result_if: valid/ready channels of the sensor frame
// sync decoder. Depends on sfsd_pkg for the payload widths.

interface sfsd_rx_if;
  logic                          valid;
  logic                          ready;
  logic [sfsd_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfsd_result_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [sfsd_pkg::SLOT_W-1:0]   slot;
  logic [sfsd_pkg::VALUE_W-1:0]  value;
  logic [sfsd_pkg::LEN_W-1:0]    fill_count;

  modport source (output valid, output kind, output slot, output value,
                  output fill_count, input ready);
  modport sink   (input valid, input kind, input slot, input value,
                  input fill_count, output ready);
endinterface

// File: sv/sensor_frame_sync_decoder.sv
// sensor_frame_sync_decoder: header hunt, two-byte sample decode, ring slot
// and fill tracking, trailer check with retract. Depends on sfsd_pkg, sfsd_if.
//
// channel   dir  payload                          handshake
// rx        in   rx_byte[7:0]                     valid/ready
// result    out  kind, slot[9:0], value[14:0],    valid/ready
//                fill_count[10:0]
// cfg       in   cfg_wdata[10:0] (ring_length)    cfg_we, no back-pressure
//
// one byte per cycle while rx.ready is high: the byte is decoded on its transfer
// and any result is registered into the output register by that same transfer.
// rx.ready is low only while a result is held and result.ready is low.
// rst (synchronous) returns to hunting with ring_length 1024, slot and count 0.
// a cfg write restarts hunting and clears slot and count; the byte window is kept.

module sensor_frame_sync_decoder #(
  parameter int unsigned RING_DEPTH = sfsd_pkg::RING_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sfsd_pkg::LEN_W-1:0]  cfg_wdata,
  sfsd_rx_if.sink                     rx,
  sfsd_result_if.source               result
);

  localparam int unsigned DEPTH_CAP =
    (RING_DEPTH > sfsd_pkg::LEN_MAX) ? sfsd_pkg::LEN_MAX : RING_DEPTH;
  localparam logic [sfsd_pkg::LEN_W-1:0] DEPTH_CAP_L = sfsd_pkg::LEN_W'(DEPTH_CAP);

  sfsd_pkg::phase_t                  phase, phase_next;
  logic [sfsd_pkg::WINDOW_W-1:0]     byte_window, byte_window_next;
  logic [sfsd_pkg::BYTE_W-1:0]       high_part, high_part_next;
  logic [sfsd_pkg::LEN_W-1:0]        write_slot, write_slot_next;
  logic [sfsd_pkg::LEN_W-1:0]        valid_count, valid_count_next;
  logic [sfsd_pkg::LEN_W-1:0]        ring_length;

  logic                              out_valid;
  logic                              out_kind;
  logic [sfsd_pkg::SLOT_W-1:0]       out_slot;
  logic [sfsd_pkg::VALUE_W-1:0]      out_value;
  logic [sfsd_pkg::LEN_W-1:0]        out_fill;

  logic                              emit;
  logic                              emit_kind;
  logic [sfsd_pkg::SLOT_W-1:0]       emit_slot;
  logic [sfsd_pkg::VALUE_W-1:0]      emit_value;

  logic [sfsd_pkg::LEN_W-1:0]        eff_len;
  logic [sfsd_pkg::LEN_W:0]          slot_inc;
  logic                              rx_xfer;
  logic                              hdr_hit;

  // zero is taken as one, anything above the ring depth saturates
  always_comb begin
    if (ring_length == '0) begin
      eff_len = sfsd_pkg::LEN_W'(1);
    end else if (ring_length > DEPTH_CAP_L) begin
      eff_len = DEPTH_CAP_L;
    end else begin
      eff_len = ring_length;
    end
  end

  assign rx.ready = !out_valid || result.ready;
  assign rx_xfer  = rx.valid && rx.ready;

  assign byte_window_next = {byte_window[sfsd_pkg::WINDOW_W-sfsd_pkg::BYTE_W-1:0], rx.rx_byte};
  assign hdr_hit          = (byte_window_next == sfsd_pkg::HEADER_WORD);
  assign slot_inc         = {1'b0, write_slot} + (sfsd_pkg::LEN_W+1)'(1);

  always_comb begin
    phase_next       = phase;
    high_part_next   = high_part;
    write_slot_next  = write_slot;
    valid_count_next = valid_count;
    emit             = 1'b0;
    emit_kind        = sfsd_pkg::KIND_SAMPLE;
    emit_slot        = write_slot[sfsd_pkg::SLOT_W-1:0];
    emit_value       = '0;
    unique case (phase)
      sfsd_pkg::PH_HUNT: begin
        if (hdr_hit) begin
          phase_next = sfsd_pkg::PH_HIGH;
        end
      end
      sfsd_pkg::PH_HIGH: begin
        high_part_next = rx.rx_byte;
        phase_next     = sfsd_pkg::PH_LOW;
      end
      sfsd_pkg::PH_LOW: begin
        emit       = 1'b1;
        emit_slot  = write_slot[sfsd_pkg::SLOT_W-1:0];
        emit_value = sfsd_pkg::VALUE_W'(high_part)
                     * sfsd_pkg::VALUE_W'(sfsd_pkg::HUNDREDTHS_PER_UNIT)
                   + sfsd_pkg::VALUE_W'(rx.rx_byte);
        write_slot_next = (slot_inc >= {1'b0, eff_len}) ? '0 : slot_inc[sfsd_pkg::LEN_W-1:0];
        if (valid_count < eff_len) begin
          valid_count_next = valid_count + sfsd_pkg::LEN_W'(1);
        end
        phase_next = sfsd_pkg::PH_SKIP0;
      end
      sfsd_pkg::PH_SKIP0:  phase_next = sfsd_pkg::PH_SKIP1;
      sfsd_pkg::PH_SKIP1:  phase_next = sfsd_pkg::PH_SKIP2;
      sfsd_pkg::PH_SKIP2:  phase_next = sfsd_pkg::PH_SKIP3;
      sfsd_pkg::PH_SKIP3:  phase_next = sfsd_pkg::PH_CHECK0;
      sfsd_pkg::PH_CHECK0: phase_next = sfsd_pkg::PH_CHECK1;
      sfsd_pkg::PH_CHECK1: phase_next = sfsd_pkg::PH_CHECK2;
      sfsd_pkg::PH_CHECK2: begin
        if (hdr_hit) begin
          phase_next = sfsd_pkg::PH_HIGH;
        end else begin
          // lost lock: step the slot back, wrapping below zero
          if (write_slot == '0 || write_slot > eff_len) begin
            write_slot_next = eff_len - sfsd_pkg::LEN_W'(1);
          end else begin
            write_slot_next = write_slot - sfsd_pkg::LEN_W'(1);
          end
          emit       = 1'b1;
          emit_kind  = sfsd_pkg::KIND_RETRACT;
          emit_slot  = write_slot_next[sfsd_pkg::SLOT_W-1:0];
          phase_next = sfsd_pkg::PH_HUNT;
        end
      end
      default: phase_next = sfsd_pkg::PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= sfsd_pkg::PH_HUNT;
      byte_window <= '0;
      high_part   <= '0;
      write_slot  <= '0;
      valid_count <= '0;
      ring_length <= sfsd_pkg::LEN_RESET;
    end else if (cfg_we) begin
      ring_length <= cfg_wdata;
      phase       <= sfsd_pkg::PH_HUNT;
      write_slot  <= '0;
      valid_count <= '0;
    end else if (rx_xfer) begin
      phase       <= phase_next;
      byte_window <= byte_window_next;
      high_part   <= high_part_next;
      write_slot  <= write_slot_next;
      valid_count <= valid_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx_xfer) begin
      out_valid <= emit;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_xfer && emit) begin
      out_kind  <= emit_kind;
      out_slot  <= emit_slot;
      out_value <= emit_value;
      out_fill  <= valid_count_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.kind       = out_kind;
  assign result.slot       = out_slot;
  assign result.value      = out_value;
  assign result.fill_count = out_fill;

  a_slot_in_ring: assert property (@(posedge clk) disable iff (rst)
    write_slot < eff_len)
    else $error("write slot outside ring");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    valid_count <= eff_len)
    else $error("fill count above ring length");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (phase == sfsd_pkg::PH_HUNT && write_slot == '0 && valid_count == '0))
    else $error("config write did not restart hunting");

  a_low_emits: assert property (@(posedge clk) disable iff (rst)
    (rx_xfer && !cfg_we && phase == sfsd_pkg::PH_LOW) |=>
      (out_valid && out_kind == sfsd_pkg::KIND_SAMPLE && phase == sfsd_pkg::PH_SKIP0))
    else $error("decoded frame gave no sample");

  a_retract_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == sfsd_pkg::KIND_RETRACT) |-> (out_value == '0))
    else $error("retract with non-zero value");

endmodule
